// ===== hw/rtl/compact_uint56_encoder_top_assert.svh =====
// Assertion macros for the compact uint56 encoder.
// Used at the end of compact_uint56_encoder_top; no other dependencies.
`ifndef COMPACT_UINT56_ENCODER_TOP_ASSERT_SVH
`define COMPACT_UINT56_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define CU56_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CU56_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cu56_pkg.sv =====
// Shared types and constants for the compact uint56 encoder.
// No dependencies.
package cu56_pkg;

  localparam int VALUE_W      = 64;
  localparam int LIMIT_BITS   = 56;
  localparam int GROUP_BITS   = 7;
  localparam int MAX_BYTES    = 8;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 3;
  localparam int QUEUE_DEPTH  = 2;

  // One classified value waiting for serialization
  typedef struct packed {
    logic [VALUE_W-1:0] enc;       // encoded word, low bytes first
    logic [CNT_W-1:0]   last_idx;  // byte count minus one
    logic               err;       // value exceeded 56 bits
  } cu56_entry_t;

endpackage

// ===== hw/rtl/cu56_front.sv =====
// Front end: classify one value and build its encoded word.
// Depends on cu56_pkg.
module cu56_front import cu56_pkg::*; (
  input  logic [VALUE_W-1:0] value,
  output cu56_entry_t        entry
);

  logic [MAX_BYTES-1:0] group_nz;
  logic [CNT_W-1:0]     top_idx;
  logic [CNT_W:0]       nbytes;
  logic                 err;
  logic [VALUE_W-1:0]   shifted;
  logic [VALUE_W-1:0]   marker;

  // Flag each nonzero 7-bit group of the low 56 bits
  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      group_nz[i] = |value[i*GROUP_BITS +: GROUP_BITS];
    end
  end

  // Find the highest nonzero group; zero falls back to one byte
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < MAX_BYTES; i++) begin
      if (group_nz[i]) top_idx = CNT_W'(i);
    end
  end

  assign err     = |value[VALUE_W-1:LIMIT_BITS];
  assign nbytes  = {1'b0, top_idx} + 1'b1;
  assign shifted = {{(VALUE_W-LIMIT_BITS){1'b0}}, value[LIMIT_BITS-1:0]} << nbytes;
  assign marker  = {{(VALUE_W-1){1'b0}}, 1'b1} << top_idx;

  // Out-of-range values become a single zero byte with the error flag
  always_comb begin
    entry.err = err;
    if (err) begin
      entry.enc      = '0;
      entry.last_idx = '0;
    end else begin
      entry.enc      = shifted | marker;
      entry.last_idx = top_idx;
    end
  end

endmodule

// ===== hw/rtl/cu56_queue.sv =====
// Short queue between the classifier and the byte serializer.
// Depends on cu56_pkg.
module cu56_queue import cu56_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  cu56_entry_t wr_data,
  output logic        full,
  input  logic        rd_en,
  output cu56_entry_t rd_data,
  output logic        rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cu56_entry_t   slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cu56_back.sv =====
// Back end: shift an encoded word out into an output register, one byte per cycle while that register is free.
// Depends on cu56_pkg.
module cu56_back import cu56_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cu56_entry_t       q_data,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              last_byte,
  output logic              range_error
);

  logic               work_valid;
  logic [VALUE_W-1:0] work_enc;
  logic [CNT_W-1:0]   work_left;
  logic               work_err;
  logic               out_valid;
  logic               out_free;
  logic               move;
  logic               work_last;

  assign out_free  = !out_valid || pop;
  assign move      = work_valid && out_free;
  assign work_last = (work_left == '0);
  assign q_pop     = q_valid && (!work_valid || (move && work_last));
  assign empty     = !out_valid;

  // Load a new word, or advance the current one by a byte
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (q_pop) begin
      work_valid <= 1'b1;
    end else if (move && work_last) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_enc  <= q_data.enc;
      work_left <= q_data.last_idx;
      work_err  <= q_data.err;
    end else if (move) begin
      work_enc  <= work_enc >> BYTE_W;
      work_left <= work_left - 1'b1;
    end
  end

  // Hold the result until taken; refill when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte    <= work_enc[BYTE_W-1:0];
      last_byte   <= work_last;
      range_error <= work_err;
    end
  end

endmodule

// ===== hw/rtl/compact_uint56_encoder_top.sv =====
// Compact uint56 prefix-varint encoder, top level.
// Depends on cu56_pkg, cu56_front, cu56_queue, cu56_back and the assert header.
//
// Usage:
//   Input channel: drive value and push; a word is taken at a clock edge
//   with push high and full low. Each value fits in 56 bits or is flagged.
//   Result channel: while empty is low, out_byte, last_byte and range_error
//   hold the oldest byte; pop high at a clock edge takes it.
//   Each value yields 1 to 8 bytes, least significant first, last_byte on
//   the final one. Zero yields 0x01. A value above 56 bits yields one zero
//   byte with range_error set.
//   The first byte becomes visible after the value has passed the queue,
//   the serializer's working register and its output register.
//   Throughput: one byte per cycle while pop stays high; the classifier
//   takes a new value every cycle while the queue has room.
//   Reset (rst, synchronous) empties the queue and the output register.
//   A stalled receiver holds the current byte; the serializer and then the
//   queue fill, and full rises until bytes drain again.
`include "compact_uint56_encoder_top_assert.svh"

module compact_uint56_encoder_top import cu56_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [VALUE_W-1:0] value,
  output logic               empty,
  input  logic               pop,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               last_byte,
  output logic               range_error
);

  cu56_entry_t front_entry;
  cu56_entry_t q_data;
  logic        q_valid;
  logic        q_pop;

  // Classify the incoming value
  cu56_front u_front (
    .value (value),
    .entry (front_entry)
  );

  // Decouple classification from serialization
  cu56_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (front_entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  // Serialize words into bytes
  cu56_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .range_error (range_error)
  );

  // An error result is a lone zero byte
  `CU56_ASSERT_NOW(a_err_byte, clk, rst, !empty && range_error, out_byte == '0 && last_byte, "error result not a lone zero byte")

  // Taking a non-final byte leaves the next byte of the same word ready
  `CU56_ASSERT_NEXT(a_no_gap, clk, rst, pop && !empty && !last_byte, !empty, "gap inside an encoded value")

  // Serializer only pulls from the queue when it holds a word
  `CU56_ASSERT_NOW(a_pop_valid, clk, rst, q_pop, q_valid, "queue read while empty")

  // Output is empty right after reset
  `CU56_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), empty, "result present after reset")

endmodule
